/* rtl/core/fixed_point_alu_q24_8_macros.svh */
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q24_8_MACROS_SVH
`define FIXED_POINT_ALU_Q24_8_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen outside reset.
`define FPA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Widths, opcodes and the sideband record that travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;
  // Dividend width: operand magnitude followed by the fraction bits.
  localparam int NUMW      = DATA_W + FRAC_BITS;
  // A remainder stays below the divisor magnitude, which is at most 2^31.
  localparam int REMW      = DATA_W - 1;

  localparam logic [DATA_W-1:0] RAW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] RAW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_GT   = 4'd4,
    OP_LT   = 4'd5,
    OP_GE   = 4'd6,
    OP_LE   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_INC  = 4'd10,
    OP_DEC  = 4'd11,
    OP_MIN  = 4'd12,
    OP_MAX  = 4'd13,
    OP_FINT = 4'd14,
    OP_TINT = 4'd15
  } op_t;

  // Result of every operation but a real division, plus what the divider's
  // back end needs to finish one.
  typedef struct packed {
    logic              is_div;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic              cmp;
    logic              dbz;
    logic              sat;
  } side_t;

endpackage

`default_nettype wire

/* rtl/core/fixed_point_alu_q24_8.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU, Q24.8
// Signed 32-bit fixed-point ALU with saturation and rounded multiply/divide.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+-------------------------------------------------
//  in      | input     | in_valid, in_ready, in_opcode, in_operand_a/b
//  out     | output    | out_valid, out_ready, out_result_value, flags
//
//  One beat is accepted every cycle while the output side takes results.
//  Every opcode travels the same path, through a divider that resolves one
//  quotient bit per stage.
//  A stall on the output freezes the whole pipeline; nothing is lost or repeated.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_q24_8 (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [3:0]                        in_opcode,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] in_operand_a,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] in_operand_b,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [fpa_pkg::DATA_W-1:0]      out_result_value,
  output logic                                   out_compare_true,
  output logic                                   out_divide_by_zero,
  output logic                                   out_saturated
);
  import fpa_pkg::*;
`include "fixed_point_alu_q24_8_macros.svh"

  localparam logic [NUMW:0] POS_LIM = (NUMW+1)'(RAW_MAX);
  localparam logic [NUMW:0] NEG_LIM = (NUMW+1)'(RAW_MAX) + (NUMW+1)'(1);

  logic en;

  // The pipeline advances whenever the output register is free or drains.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic              f_valid;
  side_t             f_side;
  logic [NUMW-1:0]   f_num;
  logic [DATA_W-1:0] f_den;

  fpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .in_opcode    (in_opcode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (f_valid),
    .out_side     (f_side),
    .out_num      (f_num),
    .out_den      (f_den)
  );

  logic              d_valid;
  logic [NUMW-1:0]   d_quot;
  logic [REMW-1:0]   d_rem;
  logic [DATA_W-1:0] d_den;
  side_t             d_side;

  fpa_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_quot  (d_quot),
    .out_rem   (d_rem),
    .out_den   (d_den),
    .out_side  (d_side)
  );

  // Finish a division: round half away from zero, then clamp.
  logic [NUMW:0] div_m;
  side_t         fin;

  assign div_m = {1'b0, d_quot} + (NUMW+1)'(({d_rem, 1'b0} >= d_den) ? 1 : 0);

  always_comb begin
    fin = d_side;
    if (d_side.is_div) begin
      if (!d_side.neg && (div_m > POS_LIM)) begin
        fin.sat = 1'b1;
        fin.res = RAW_MAX;
      end else if (d_side.neg && (div_m > NEG_LIM)) begin
        fin.sat = 1'b1;
        fin.res = RAW_MIN;
      end else begin
        fin.res = d_side.neg ? (DATA_W'(0) - div_m[DATA_W-1:0]) : div_m[DATA_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
    if (en) begin
      out_result_value   <= fin.res;
      out_compare_true   <= fin.cmp;
      out_divide_by_zero <= fin.dbz;
      out_saturated      <= fin.sat;
    end
  end

  // A beat with the compare flag set carries a zero result and no other flag.
  `FPA_ASSERT(a_cmp_zero, out_valid && out_compare_true |-> out_result_value == '0 && !out_divide_by_zero && !out_saturated, "comparison beat with result or flags")
  // A division by zero never also saturates.
  `FPA_NEVER(a_dbz_sat, out_valid && out_divide_by_zero && out_saturated, "divide by zero flagged as saturated")
  // A saturated result sits at one end of the range.
  `FPA_ASSERT(a_sat_end, out_valid && out_saturated |-> out_result_value == RAW_MAX || out_result_value == RAW_MIN, "saturated result not at a range end")
  // An output beat held during a stall is not dropped.
  `FPA_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid, "output beat lost during stall")

endmodule

`default_nettype wire

/* rtl/core/fpa_front.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Three register stages: operand capture, simple ops and the multiply, then
// multiply rounding and saturation. Prepares divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [3:0]                  in_opcode,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] in_operand_a,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] in_operand_b,
  output logic                             out_valid,
  output fpa_pkg::side_t                   out_side,
  output logic [fpa_pkg::NUMW-1:0]         out_num,
  output logic [fpa_pkg::DATA_W-1:0]       out_den
);
  import fpa_pkg::*;

  localparam int PW = 2 * DATA_W;
  localparam logic [PW-1:0] HALF = (PW'(1) << FRAC_BITS) >> 1;
  localparam logic [PW-1:0] POS_LIM = PW'(RAW_MAX);
  localparam logic [PW-1:0] NEG_LIM = PW'(RAW_MAX) + PW'(1);

  // Clamp a 33-bit signed sum to the 32-bit range.
  function automatic side_t clamp33(input logic signed [DATA_W:0] v);
    side_t s;
    s = '0;
    if (v[DATA_W] != v[DATA_W-1]) begin
      s.sat = 1'b1;
      s.res = v[DATA_W] ? RAW_MIN : RAW_MAX;
    end else begin
      s.res = v[DATA_W-1:0];
    end
    return s;
  endfunction

  // Stage 1: operand capture.
  logic                     s1_valid_r;
  op_t                      s1_op_r;
  logic signed [DATA_W-1:0] s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
    if (en) begin
      s1_op_r <= op_t'(in_opcode);
      s1_a_r  <= in_operand_a;
      s1_b_r  <= in_operand_b;
    end
  end

  // Stage 2 logic: magnitudes, simple ops, and the multiply.
  logic [DATA_W-1:0] mag_a, mag_b;
  logic              neg;
  side_t             s2_side_nxt;
  logic signed [DATA_W:0]    sum_ab, dif_ab, inc_a, dec_a;
  logic signed [PW-1:0]      fint;

  assign mag_a = s1_a_r[DATA_W-1] ? (DATA_W'(0) - s1_a_r) : s1_a_r;
  assign mag_b = s1_b_r[DATA_W-1] ? (DATA_W'(0) - s1_b_r) : s1_b_r;
  assign neg   = s1_a_r[DATA_W-1] ^ s1_b_r[DATA_W-1];
  assign sum_ab = {s1_a_r[DATA_W-1], s1_a_r} + {s1_b_r[DATA_W-1], s1_b_r};
  assign dif_ab = {s1_a_r[DATA_W-1], s1_a_r} - {s1_b_r[DATA_W-1], s1_b_r};
  assign inc_a  = {s1_a_r[DATA_W-1], s1_a_r} + (DATA_W+1)'(1);
  assign dec_a  = {s1_a_r[DATA_W-1], s1_a_r} - (DATA_W+1)'(1);
  assign fint   = PW'(s1_a_r) <<< FRAC_BITS;

  always_comb begin
    s2_side_nxt     = '0;
    s2_side_nxt.neg = neg;
    unique case (s1_op_r)
      OP_ADD:  s2_side_nxt = clamp33(sum_ab);
      OP_SUB:  s2_side_nxt = clamp33(dif_ab);
      OP_MUL:  s2_side_nxt.neg = neg;
      OP_DIV: begin
        if (s1_b_r == '0) begin
          s2_side_nxt.dbz = 1'b1;
          s2_side_nxt.res = s1_a_r;
        end else begin
          s2_side_nxt.is_div = 1'b1;
          s2_side_nxt.neg    = neg;
        end
      end
      OP_GT:   s2_side_nxt.cmp = (s1_a_r >  s1_b_r);
      OP_LT:   s2_side_nxt.cmp = (s1_a_r <  s1_b_r);
      OP_GE:   s2_side_nxt.cmp = (s1_a_r >= s1_b_r);
      OP_LE:   s2_side_nxt.cmp = (s1_a_r <= s1_b_r);
      OP_EQ:   s2_side_nxt.cmp = (s1_a_r == s1_b_r);
      OP_NE:   s2_side_nxt.cmp = (s1_a_r != s1_b_r);
      OP_INC:  s2_side_nxt = clamp33(inc_a);
      OP_DEC:  s2_side_nxt = clamp33(dec_a);
      OP_MIN:  s2_side_nxt.res = (s1_a_r < s1_b_r) ? s1_a_r : s1_b_r;
      OP_MAX:  s2_side_nxt.res = (s1_a_r > s1_b_r) ? s1_a_r : s1_b_r;
      OP_FINT: begin
        if (fint > PW'(signed'(RAW_MAX))) begin
          s2_side_nxt.sat = 1'b1;
          s2_side_nxt.res = RAW_MAX;
        end else if (fint < PW'(signed'(RAW_MIN))) begin
          s2_side_nxt.sat = 1'b1;
          s2_side_nxt.res = RAW_MIN;
        end else begin
          s2_side_nxt.res = fint[DATA_W-1:0];
        end
      end
      OP_TINT: s2_side_nxt.res = s1_a_r >>> FRAC_BITS;
      default: s2_side_nxt = '0;
    endcase
  end

  // Stage 2 registers.
  logic              s2_valid_r, s2_mul_r;
  side_t             s2_side_r;
  logic [PW-1:0]     s2_prod_r;
  logic [NUMW-1:0]   s2_num_r;
  logic [DATA_W-1:0] s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en) begin
      s2_mul_r  <= (s1_op_r == OP_MUL);
      s2_side_r <= s2_side_nxt;
      s2_prod_r <= mag_a * mag_b;
      s2_num_r  <= {mag_a, {FRAC_BITS{1'b0}}};
      s2_den_r  <= mag_b;
    end
  end

  // Stage 3 logic: round the product half away from zero and clamp.
  logic [PW-1:0] mul_m;
  side_t         s3_side_nxt;

  assign mul_m = (s2_prod_r + HALF) >> FRAC_BITS;

  always_comb begin
    s3_side_nxt = s2_side_r;
    if (s2_mul_r) begin
      if (!s2_side_r.neg && (mul_m > POS_LIM)) begin
        s3_side_nxt.sat = 1'b1;
        s3_side_nxt.res = RAW_MAX;
      end else if (s2_side_r.neg && (mul_m > NEG_LIM)) begin
        s3_side_nxt.sat = 1'b1;
        s3_side_nxt.res = RAW_MIN;
      end else begin
        s3_side_nxt.res = s2_side_r.neg ? (DATA_W'(0) - mul_m[DATA_W-1:0])
                                        : mul_m[DATA_W-1:0];
      end
    end
  end

  // Stage 3 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid_r;
    end
    if (en) begin
      out_side <= s3_side_nxt;
      out_num  <= s2_num_r;
      out_den  <= s2_den_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fpa_div_stage.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU divider stage
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        valid_i,
  input  wire logic [fpa_pkg::REMW-1:0]    rem_i,
  input  wire logic [fpa_pkg::NUMW-1:0]    numq_i,
  input  wire logic [fpa_pkg::DATA_W-1:0]  den_i,
  input  wire fpa_pkg::side_t              side_i,
  output logic                             valid_o,
  output logic [fpa_pkg::REMW-1:0]         rem_o,
  output logic [fpa_pkg::NUMW-1:0]         numq_o,
  output logic [fpa_pkg::DATA_W-1:0]       den_o,
  output fpa_pkg::side_t                   side_o
);
  import fpa_pkg::*;

  logic [DATA_W-1:0] trial;
  logic [REMW-1:0]   diff;
  logic              ge;

  // Bring down the next dividend bit and try the subtraction.
  // After a successful subtraction the difference is below the divisor.
  assign trial = {rem_i, numq_i[NUMW-1]};
  assign ge    = (trial >= den_i);
  assign diff  = REMW'(trial - den_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
    if (en) begin
      rem_o  <= ge ? diff : trial[REMW-1:0];
      numq_o <= {numq_i[NUMW-2:0], ge};
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fpa_divider.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU divider
// A chain of restoring steps, one per quotient bit, with the sideband record
// carried alongside so every item keeps its place.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [fpa_pkg::NUMW-1:0]    in_num,
  input  wire logic [fpa_pkg::DATA_W-1:0]  in_den,
  input  wire fpa_pkg::side_t              in_side,
  output logic                             out_valid,
  output logic [fpa_pkg::NUMW-1:0]         out_quot,
  output logic [fpa_pkg::REMW-1:0]         out_rem,
  output logic [fpa_pkg::DATA_W-1:0]       out_den,
  output fpa_pkg::side_t                   out_side
);
  import fpa_pkg::*;

  logic              valid_c [NUMW+1];
  logic [REMW-1:0]   rem_c   [NUMW+1];
  logic [NUMW-1:0]   numq_c  [NUMW+1];
  logic [DATA_W-1:0] den_c   [NUMW+1];
  side_t             side_c  [NUMW+1];

  assign valid_c[0] = in_valid;
  assign rem_c[0]   = '0;
  assign numq_c[0]  = in_num;
  assign den_c[0]   = in_den;
  assign side_c[0]  = in_side;

  // One step per dividend bit, most significant first.
  for (genvar i = 0; i < NUMW; i++) begin : g_step
    fpa_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (valid_c[i]),
      .rem_i   (rem_c[i]),
      .numq_i  (numq_c[i]),
      .den_i   (den_c[i]),
      .side_i  (side_c[i]),
      .valid_o (valid_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .numq_o  (numq_c[i+1]),
      .den_o   (den_c[i+1]),
      .side_o  (side_c[i+1])
    );
  end

  assign out_valid = valid_c[NUMW];
  assign out_quot  = numq_c[NUMW];
  assign out_rem   = rem_c[NUMW];
  assign out_den   = den_c[NUMW];
  assign out_side  = side_c[NUMW];

endmodule

`default_nettype wire
